// File: src/mtep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared widths, codes, item types and the status byte length lookup.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int VALUE_WIDTH_DEF = 28;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int FIELD_W         = 28;
   localparam int LIMIT_W         = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

   localparam logic [8:0] TYPE_CHANNEL = 9'd256;
   localparam logic [8:0] TYPE_SYSEX   = 9'd257;
   localparam logic [8:0] TYPE_ARBIT   = 9'd258;

   localparam logic [7:0] META_SEQNO = 8'h00;
   localparam logic [7:0] META_EOT   = 8'h2f;
   localparam logic [7:0] META_TEMPO = 8'h51;

   localparam logic [7:0] STATUS_SYSEX = 8'hf0;
   localparam logic [7:0] STATUS_ARBIT = 8'hf7;
   localparam logic [7:0] STATUS_META  = 8'hff;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_NO_STATUS  = 2'd1;
   localparam logic [1:0] ERR_SHORT_META = 2'd2;

   // Commands passed from the parser to the result sequencer.
   localparam logic [2:0] CMD_ERROR  = 3'd0;
   localparam logic [2:0] CMD_HEADER = 3'd1;
   localparam logic [2:0] CMD_DATA   = 3'd2;
   localparam logic [2:0] CMD_CHAN2  = 3'd3;
   localparam logic [2:0] CMD_CHAN3  = 3'd4;

   localparam logic [1:0] SIZE_BY_NIBBLE [8] = '{
      2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd0
   };

   typedef struct packed {
      logic [1:0]         kind;
      logic [FIELD_W-1:0] delta_time;
      logic [8:0]         event_type;
      logic [FIELD_W-1:0] event_length;
      logic [7:0]         data_byte;
      logic               truncated;
      logic               end_of_track;
      logic [1:0]         error_code;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [2:0]         code;
      logic [FIELD_W-1:0] delta;
      logic [8:0]         etype;
      logic [FIELD_W-1:0] len;
      logic               trunc;
      logic               eot;
      logic [1:0]         err;
      logic [7:0]         byte0;
      logic [7:0]         byte1;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_slot_type;

   // Message length, status byte included, for a channel or system status.
   function automatic logic [1:0] msg_size(input logic [7:0] s);
      logic [1:0] len;
      len = SIZE_BY_NIBBLE[s[6:4]];
      if (len == 2'd0) begin
         if (s == STATUS_SYSEX) begin
            len = 2'd0;
         end else if (s inside {8'hf1, 8'hf3}) begin
            len = 2'd2;
         end else if (s == 8'hf2) begin
            len = 2'd3;
         end else begin
            len = 2'd1;
         end
      end
      return len;
   endfunction

endpackage

// File: src/mtep_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track byte channel
// Valid/ready channel carrying one raw track byte per item.
// ----------------------------------------------------------------------------
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source(output valid, output byte_in, input ready);
   modport sink(input valid, input byte_in, output ready);
endinterface

// File: src/mtep_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parse result channel
// Valid/ready channel carrying one header, data or error result per item.
// ----------------------------------------------------------------------------
interface mtep_rsp_if;
   logic                 valid;
   logic                 ready;
   mtep_pkg::result_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// File: src/midi_track_event_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser
// Decodes the events of a standard MIDI file track body, one byte per item.
//
// req_chan carries the raw track bytes; rsp_chan carries header, data and
// error results. csr_wr_en/csr_wr_data write the per-event storage limit
// for sysex, arbitrary and meta data (reset value 256).
// A byte is taken in every cycle while the command queue has room. The
// first result of a byte is registered in the queue and then in the output
// register. A status byte of a channel message yields two results and a data
// byte under running status yields three, while the output register drains
// one result per cycle; the queue absorbs those bursts, so the sustained rate
// is one byte per cycle as long as the bytes average no more than one result
// each. When the receiver stalls, the output register holds its result, the
// queue fills, and req_chan.ready drops once all QUEUE_DEPTH entries are used.
// Reset clears the parse state, the queue and the output valid flag and
// restores the storage limit; there is no clearing pass.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit #(
   parameter int VALUE_WIDTH = mtep_pkg::VALUE_WIDTH_DEF,
   parameter int QUEUE_DEPTH = mtep_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   mtep_req_if.sink                     req_chan,
   mtep_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [mtep_pkg::LIMIT_W-1:0] csr_wr_data
);

   mtep_pkg::queue_slot_type push;
   mtep_pkg::queue_slot_type head;
   logic                     queue_full;
   logic                     pop;

   mtep_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .queue_full (queue_full),
      .push       (push)
   );

   mtep_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (pop),
      .full (queue_full),
      .head (head)
   );

   mtep_back u_back (
      .clock(clock),
      .reset(reset),
      .head (head),
      .pop  (pop),
      .rsp  (rsp_chan)
   );

endmodule

// File: src/mtep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track byte parser
// Accepts one byte per cycle while the command queue has room, tracks the event phase and pushes one command
// per byte that yields results.
// ----------------------------------------------------------------------------
module mtep_front #(
   parameter int VALUE_WIDTH = mtep_pkg::VALUE_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   mtep_req_if.sink                     req,
   input  logic                         csr_wr_en,
   input  logic [mtep_pkg::LIMIT_W-1:0] csr_wr_data,
   input  logic                         queue_full,
   output mtep_pkg::queue_slot_type     push
);

   localparam int VW    = VALUE_WIDTH;
   localparam int LW    = mtep_pkg::LIMIT_W;
   localparam int OW    = mtep_pkg::FIELD_W;
   localparam int EXT_W = VW + OW;
   localparam int CW    = VW + LW;

   localparam logic [2:0] PH_DELTA    = 3'd0;
   localparam logic [2:0] PH_STATUS   = 3'd1;
   localparam logic [2:0] PH_METATYPE = 3'd2;
   localparam logic [2:0] PH_LENGTH   = 3'd3;
   localparam logic [2:0] PH_DATA     = 3'd4;
   localparam logic [2:0] PH_SKIP     = 3'd5;

   localparam logic [VW-1:0] VALUE_MAX = {VW{1'b1}};

   logic [2:0]    phase_ff, phase_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic [VW-1:0] delta_ff, delta_in;
   logic [7:0]    rstat_ff, rstat_in;
   logic [8:0]    ctype_ff, ctype_in;
   logic [VW-1:0] remain_ff, remain_in;
   logic [LW-1:0] emitted_ff, emitted_in;
   logic [LW-1:0] limit_ff, limit_in;

   logic            accept;
   logic [7:0]      c;
   logic [VW+6:0]   acc_shift;
   logic [VW-1:0]   vl_next;
   logic [VW-1:0]   rem_dec;
   logic [LW-1:0]   emit_inc;
   logic [1:0]      msg_len;
   logic [1:0]      msg_rem;
   logic            trunc;
   logic [CW-1:0]   len_wide;
   logic [CW-1:0]   limit_wide;
   logic [CW-1:0]   shown_wide;
   mtep_pkg::queue_slot_type push_v;

   function automatic logic [OW-1:0] to_field(input logic [VW-1:0] v);
      logic [EXT_W-1:0] e;
      e = {{OW{1'b0}}, v};
      return e[OW-1:0];
   endfunction

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;
   assign c         = req.byte_in;
   assign push      = push_v;

   // One step of a variable-length value, saturating at the value width.
   assign acc_shift = {acc_ff, 7'b0} | {{VW{1'b0}}, c[6:0]};
   assign vl_next   = (|acc_shift[VW+6:VW]) ? VALUE_MAX : acc_shift[VW-1:0];

   assign rem_dec    = remain_ff - VW'(1);
   assign emit_inc   = emitted_ff + LW'(1);
   assign len_wide   = CW'(vl_next);
   assign limit_wide = CW'(limit_ff);
   assign trunc      = len_wide > limit_wide;
   assign shown_wide = trunc ? limit_wide : len_wide;

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      delta_in   = delta_ff;
      rstat_in   = rstat_ff;
      ctype_in   = ctype_ff;
      remain_in  = remain_ff;
      emitted_in = emitted_ff;
      limit_in   = csr_wr_en ? csr_wr_data : limit_ff;
      msg_len    = 2'd0;
      msg_rem    = 2'd0;
      push_v           = '0;
      push_v.cmd.delta = to_field(delta_ff);
      push_v.cmd.etype = ctype_ff;
      push_v.cmd.err   = mtep_pkg::ERR_NONE;

      if (accept) begin
         case (phase_ff)
            PH_STATUS: begin
               if (c == mtep_pkg::STATUS_SYSEX || c == mtep_pkg::STATUS_ARBIT) begin
                  ctype_in = (c == mtep_pkg::STATUS_SYSEX) ? mtep_pkg::TYPE_SYSEX
                                                           : mtep_pkg::TYPE_ARBIT;
                  acc_in   = '0;
                  phase_in = PH_LENGTH;
               end else if (c == mtep_pkg::STATUS_META) begin
                  phase_in = PH_METATYPE;
               end else begin
                  ctype_in         = mtep_pkg::TYPE_CHANNEL;
                  push_v.valid     = 1'b1;
                  push_v.cmd.etype = mtep_pkg::TYPE_CHANNEL;
                  if (c[7]) begin
                     if (c < mtep_pkg::STATUS_SYSEX) begin
                        rstat_in = c;
                     end
                     msg_len          = mtep_pkg::msg_size(c);
                     msg_rem          = msg_len - 2'd1;
                     push_v.cmd.code  = mtep_pkg::CMD_CHAN2;
                     push_v.cmd.len   = OW'(msg_len);
                     push_v.cmd.byte0 = c;
                     push_v.cmd.last  = (msg_rem == 2'd0);
                     remain_in        = VW'(msg_rem);
                     phase_in         = (msg_rem == 2'd0) ? PH_DELTA : PH_DATA;
                  end else if (rstat_ff == 8'd0) begin
                     // A data byte with no running status is dropped and reported as an error.
                     push_v.cmd.code = mtep_pkg::CMD_ERROR;
                     push_v.cmd.err  = mtep_pkg::ERR_NO_STATUS;
                     push_v.cmd.last = 1'b1;
                     phase_in        = PH_DELTA;
                  end else begin
                     msg_len          = mtep_pkg::msg_size(rstat_ff);
                     msg_rem          = msg_len - 2'd2;
                     push_v.cmd.code  = mtep_pkg::CMD_CHAN3;
                     push_v.cmd.len   = OW'(msg_len);
                     push_v.cmd.byte0 = rstat_ff;
                     push_v.cmd.byte1 = c;
                     push_v.cmd.last  = (msg_rem == 2'd0);
                     remain_in        = VW'(msg_rem);
                     phase_in         = (msg_rem == 2'd0) ? PH_DELTA : PH_DATA;
                  end
               end
            end
            PH_METATYPE: begin
               ctype_in = {1'b0, c};
               acc_in   = '0;
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               acc_in = vl_next;
               if (!c[7]) begin
                  acc_in       = '0;
                  remain_in    = vl_next;
                  push_v.valid = 1'b1;
                  if ((ctype_ff == {1'b0, mtep_pkg::META_SEQNO} && vl_next < VW'(2)) ||
                      (ctype_ff == {1'b0, mtep_pkg::META_TEMPO} && vl_next < VW'(3))) begin
                     push_v.cmd.code = mtep_pkg::CMD_ERROR;
                     push_v.cmd.err  = mtep_pkg::ERR_SHORT_META;
                     push_v.cmd.len  = to_field(vl_next);
                     push_v.cmd.last = 1'b1;
                     phase_in        = (vl_next == '0) ? PH_DELTA : PH_SKIP;
                  end else begin
                     push_v.cmd.code  = mtep_pkg::CMD_HEADER;
                     push_v.cmd.len   = shown_wide[OW-1:0];
                     push_v.cmd.trunc = trunc;
                     push_v.cmd.eot   = (ctype_ff == {1'b0, mtep_pkg::META_EOT});
                     push_v.cmd.last  = (shown_wide == '0);
                     emitted_in       = '0;
                     phase_in         = (vl_next == '0) ? PH_DELTA : PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               remain_in        = rem_dec;
               push_v.cmd.code  = mtep_pkg::CMD_DATA;
               push_v.cmd.byte0 = c;
               if (ctype_ff == mtep_pkg::TYPE_CHANNEL) begin
                  push_v.valid    = 1'b1;
                  push_v.cmd.last = (rem_dec == '0);
               end else if (emitted_ff < limit_ff) begin
                  emitted_in      = emit_inc;
                  push_v.valid    = 1'b1;
                  push_v.cmd.last = (rem_dec == '0) || (emit_inc >= limit_ff);
               end
               if (rem_dec == '0) begin
                  phase_in = PH_DELTA;
               end
            end
            PH_SKIP: begin
               remain_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_DELTA;
               end
            end
            default: begin
               // Delta time; the unused phase codes behave the same way.
               acc_in = vl_next;
               if (!c[7]) begin
                  delta_in = vl_next;
                  acc_in   = '0;
                  phase_in = PH_STATUS;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DELTA;
         acc_ff     <= '0;
         delta_ff   <= '0;
         rstat_ff   <= '0;
         ctype_ff   <= '0;
         remain_ff  <= '0;
         emitted_ff <= '0;
         limit_ff   <= mtep_pkg::LIMIT_RESET;
      end else begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         delta_ff   <= delta_in;
         rstat_ff   <= rstat_in;
         ctype_ff   <= ctype_in;
         remain_ff  <= remain_in;
         emitted_ff <= emitted_in;
         limit_ff   <= limit_in;
      end
   end

endmodule

// File: src/mtep_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO of parser commands between the parser and the sequencer.
// ----------------------------------------------------------------------------
module mtep_queue #(
   parameter int QUEUE_DEPTH = mtep_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mtep_pkg::queue_slot_type push,
   input  logic                     pop,
   output logic                     full,
   output mtep_pkg::queue_slot_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   mtep_pkg::cmd_type mem [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/mtep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result sequencer
// Expands each queued command into one to three results and holds them in
// an output register until the receiver takes them.
// ----------------------------------------------------------------------------
module mtep_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mtep_pkg::queue_slot_type head,
   output logic                     pop,
   mtep_rsp_if.source               rsp
);

   logic                 out_valid_ff, out_valid_in;
   mtep_pkg::result_type out_ff, out_in;
   logic [1:0]           sub_ff, sub_in;
   mtep_pkg::result_type res;
   logic                 final_res;
   logic                 load;

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;
   assign load        = !out_valid_ff || rsp.ready;

   always_comb begin
      res            = '0;
      res.delta_time = head.cmd.delta;
      res.event_type = head.cmd.etype;
      final_res      = 1'b1;
      case (head.cmd.code)
         mtep_pkg::CMD_ERROR: begin
            res.kind         = mtep_pkg::KIND_ERROR;
            res.event_length = head.cmd.len;
            res.error_code   = head.cmd.err;
            res.last         = 1'b1;
         end
         mtep_pkg::CMD_HEADER: begin
            res.kind         = mtep_pkg::KIND_HEADER;
            res.event_length = head.cmd.len;
            res.truncated    = head.cmd.trunc;
            res.end_of_track = head.cmd.eot;
            res.last         = head.cmd.last;
         end
         mtep_pkg::CMD_DATA: begin
            res.kind      = mtep_pkg::KIND_DATA;
            res.data_byte = head.cmd.byte0;
            res.last      = head.cmd.last;
         end
         mtep_pkg::CMD_CHAN2, mtep_pkg::CMD_CHAN3: begin
            // Header first, then the status byte, then the byte that came in
            // under running status.
            if (sub_ff == 2'd0) begin
               res.kind         = mtep_pkg::KIND_HEADER;
               res.event_length = head.cmd.len;
               final_res        = 1'b0;
            end else if (sub_ff == 2'd1) begin
               res.kind      = mtep_pkg::KIND_DATA;
               res.data_byte = head.cmd.byte0;
               final_res     = (head.cmd.code == mtep_pkg::CMD_CHAN2);
               res.last      = final_res && head.cmd.last;
            end else begin
               res.kind      = mtep_pkg::KIND_DATA;
               res.data_byte = head.cmd.byte1;
               res.last      = head.cmd.last;
            end
         end
         default: begin
            res.kind = mtep_pkg::KIND_ERROR;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      sub_in       = sub_ff;
      pop          = 1'b0;
      if (load) begin
         out_valid_in = head.valid;
         out_in       = res;
         if (head.valid) begin
            if (final_res) begin
               pop    = 1'b1;
               sub_in = 2'd0;
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sub_ff       <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         sub_ff       <= sub_in;
      end
   end

endmodule

// File: src/mtep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mtep_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mtep_pkg::result_type rsp_payload
);

   // A stalled result stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // Data items carry no header or error information.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == mtep_pkg::KIND_DATA |->
         !rsp_payload.truncated && !rsp_payload.end_of_track &&
         rsp_payload.error_code == mtep_pkg::ERR_NONE &&
         rsp_payload.event_length == '0)
      else $error("data item carries header fields");

   // A channel message header is never marked last, truncated or end of track, since its status byte follows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == mtep_pkg::KIND_HEADER &&
         rsp_payload.event_type == mtep_pkg::TYPE_CHANNEL |->
         !rsp_payload.last && !rsp_payload.truncated && !rsp_payload.end_of_track)
      else $error("channel header marked last or truncated");

endmodule

bind midi_track_event_parser_unit mtep_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_payload(rsp_chan.payload)
);
